>>> hw/rtl/mcsc_pkg.sv
// Shared types, constants and shift tables for the multiview census/SAD cost block.
// No dependencies; imported by every module of the block.
`default_nettype none

package mcsc_pkg;

  localparam int VIEWS     = 7;
  localparam int CENTRE    = VIEWS / 2;
  localparam int VIEW_W    = 3;
  localparam int MAX_DISP  = 16;
  localparam int MAX_WIN   = 15;

  localparam int AD_W      = 24;
  localparam int CNT_W     = 8;
  localparam int NUM_W     = 32;
  localparam int TOT_W     = 35;
  localparam int DEN_W     = 32;
  localparam int COST_W    = 19;
  localparam int FRAC_W    = 16;
  localparam int DIVN_W    = DEN_W + COST_W;

  localparam logic [COST_W-1:0] COST_ONE = COST_W'(1 << FRAC_W);

  typedef struct packed {
    logic              start;
    logic [TOT_W-1:0]  dividend;
    logic [DEN_W-1:0]  divisor;
  } div_req_t;

  function automatic logic signed [5:0] clamp_disp(input logic [5:0] v);
    logic signed [5:0] s;
    s = $signed(v);
    if (s > 6'sd16) return 6'sd16;
    else if (s < -6'sd16) return -6'sd16;
    else return s;
  endfunction

  function automatic logic [4:0] round_866(input logic [5:0] m);
    case (m)
      6'd0:    round_866 = 5'd0;
      6'd1:    round_866 = 5'd1;
      6'd2:    round_866 = 5'd2;
      6'd3:    round_866 = 5'd3;
      6'd4:    round_866 = 5'd3;
      6'd5:    round_866 = 5'd4;
      6'd6:    round_866 = 5'd5;
      6'd7:    round_866 = 5'd6;
      6'd8:    round_866 = 5'd7;
      6'd9:    round_866 = 5'd8;
      6'd10:   round_866 = 5'd9;
      6'd11:   round_866 = 5'd10;
      6'd12:   round_866 = 5'd10;
      6'd13:   round_866 = 5'd11;
      6'd14:   round_866 = 5'd12;
      6'd15:   round_866 = 5'd13;
      default: round_866 = 5'd14;
    endcase
  endfunction

  function automatic logic signed [5:0] row_off(input logic [2:0] v,
                                                input logic signed [5:0] d);
    logic [5:0] m;
    logic [4:0] o;
    logic       neg;
    m = d[5] ? 6'(-d) : d;
    o = round_866(m);
    neg = d[5];
    case (v) inside
      3'd0, 3'd1: row_off = neg ? $signed({1'b0, o}) : -$signed({1'b0, o});
      3'd5, 3'd6: row_off = neg ? -$signed({1'b0, o}) : $signed({1'b0, o});
      default:    row_off = 6'sd0;
    endcase
  endfunction

  function automatic logic signed [5:0] col_off(input logic [2:0] v,
                                                input logic signed [5:0] d);
    logic signed [7:0] x;
    logic signed [7:0] t;
    logic signed [7:0] h;
    x = {{2{d[5]}}, d};
    case (v) inside
      3'd0, 3'd5: t = -x;
      3'd1, 3'd6: t = x;
      3'd2:       t = -(x <<< 1);
      3'd4:       t = x <<< 1;
      default:    t = 8'sd0;
    endcase
    h = (t + 8'sd1) >>> 1;
    col_off = h[5:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mcsc_store.sv
// Pixel store: one image per view, single port, registered read data.
// Depends on mcsc_pkg for the view count.
`default_nettype none

module mcsc_store import mcsc_pkg::*; #(
  parameter int IMAGE_SIZE = 256,
  parameter int PIXEL_BITS = 16
) (
  input  wire logic                                           clk,
  input  wire logic                                           we,
  input  wire logic [VIEW_W+2*$clog2(IMAGE_SIZE)-1:0]          addr,
  input  wire logic [PIXEL_BITS-1:0]                          wdata,
  output logic      [PIXEL_BITS-1:0]                          rdata
);

  localparam int AW    = $clog2(IMAGE_SIZE);
  localparam int DEPTH = VIEWS << (2 * AW);

  logic [PIXEL_BITS-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/mcsc_divider.sv
// Restoring divider, one quotient bit per cycle, rounded and saturated cost out.
// Depends on mcsc_pkg for widths and the request struct.
`default_nettype none

module mcsc_divider import mcsc_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire div_req_t            req,
  output logic                     done,
  output logic [COST_W-1:0]        quot
);

  logic [DIVN_W-1:0] rem;
  logic [DIVN_W-1:0] dsh;
  logic [COST_W:0]   q;
  logic [4:0]        step;
  logic              busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem  <= {req.dividend, {FRAC_W{1'b0}}} + DIVN_W'(req.divisor >> 1);
        dsh  <= {req.divisor, {COST_W{1'b0}}};
        step <= 5'(COST_W);
        busy <= 1'b1;
      end else if (busy) begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          q   <= {q[COST_W-1:0], 1'b1};
        end else begin
          q   <= {q[COST_W-1:0], 1'b0};
        end
        dsh <= dsh >> 1;
        if (step == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 5'd1;
        end
      end
    end
  end

  assign quot = q[COST_W] ? {COST_W{1'b1}} : q[COST_W-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/multiview_census_sad_cost.sv
// Top level: request sequencer, window accumulator and shared multiplier.
// Depends on mcsc_pkg, mcsc_store and mcsc_divider.
//
//   channel  signals                                   direction
//   in       in_valid/in_stall, command..disparity     request in
//   out      out_valid/out_stall, result_view..oor     result out
//   cfg      cfg_write, cfg_index, cfg_data            register write
//
// A load request is written to the store while the block is idle. A compute
// request holds in_stall high until its last result is emitted: the single
// store port serves one pixel a cycle and the divider yields one quotient bit
// a cycle. Flagged and zero disparity requests skip the reads and the divider.
// Reset is synchronous; it does not clear the store.
// out_stall only holds the sequencer at its emit step.
`default_nettype none

module multiview_census_sad_cost import mcsc_pkg::*; #(
  parameter int IMAGE_SIZE = 256,
  parameter int PIXEL_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                command,
  input  wire logic [2:0]          view,
  input  wire logic [7:0]          row,
  input  wire logic [7:0]          column,
  input  wire logic [15:0]         pixel_value,
  input  wire logic signed [5:0]   disparity,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [2:0]               result_view,
  output logic [18:0]              cost,
  output logic                     last,
  output logic                     out_of_range,
  input  wire logic                cfg_write,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [15:0]         cfg_data
);

  localparam int AW     = $clog2(IMAGE_SIZE);
  localparam int CW     = ((AW > 8) ? AW : 8) + 3;
  localparam int ADDR_W = VIEW_W + 2 * AW;

  localparam logic [2:0] REG_MIN_DISP = 3'd0;
  localparam logic [2:0] REG_MAX_DISP = 3'd1;
  localparam logic [2:0] REG_WINDOW   = 3'd2;
  localparam logic [2:0] REG_BLEND    = 3'd3;
  localparam logic [2:0] REG_TRUNC    = 3'd4;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  localparam logic [2:0] CENTRE_V = 3'(CENTRE);
  localparam logic [2:0] LAST_V   = 3'(VIEWS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_DEN1, S_DEN2, S_READ, S_DRAIN,
    S_MUL1, S_MUL2, S_MUL3, S_DIVGO, S_DIVWAIT, S_EMIT
  } state_t;

  typedef enum logic [1:0] {RK_REFC, RK_SHC, RK_Q, RK_P} rd_kind_t;

  state_t            state;
  rd_kind_t          ph;
  rd_kind_t          tag_kind;
  logic              tag_vld;

  logic signed [5:0] min_disp;
  logic signed [5:0] max_disp;
  logic [3:0]        win;
  logic [8:0]        alpha;
  logic [15:0]       trunc;

  logic [7:0]        cr;
  logic [7:0]        cc;
  logic signed [5:0] cd;
  logic [2:0]        v;
  logic              fin;
  logic [3:0]        hc;
  logic [3:0]        wc;

  logic [15:0]       ref_c;
  logic [15:0]       sh_c;
  logic [15:0]       q_pix;
  logic [AD_W-1:0]   ad;
  logic [CNT_W-1:0]  cnt;
  logic [16:0]       tmp;
  logic [NUM_W-1:0]  num;
  logic [TOT_W-1:0]  total;
  logic [DEN_W-1:0]  den;

  logic [2:0]        res_view;
  logic [COST_W-1:0] res_cost;
  logic              res_last;
  logic              res_oor;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      min_disp <= -6'sd8;
      max_disp <= 6'sd8;
      win      <= 4'd5;
      alpha    <= 9'd128;
      trunc    <= 16'd350;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MIN_DISP: min_disp <= clamp_disp(cfg_data[5:0]);
        REG_MAX_DISP: max_disp <= clamp_disp(cfg_data[5:0]);
        REG_WINDOW:   win      <= (cfg_data[3:0] == 4'd0) ? 4'd1 : cfg_data[3:0];
        REG_BLEND:    alpha    <= (cfg_data[8:0] > 9'd256) ? 9'd256 : cfg_data[8:0];
        REG_TRUNC:    trunc    <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
        default: ;
      endcase
    end
  end

  // border and range check
  logic [2:0]          hws;
  logic [3:0]          span;
  logic [5:0]          amin;
  logic [5:0]          amax;
  logic [5:0]          pad;
  logic signed [CW-1:0] hws_s;
  logic signed [CW-1:0] pad_s;
  logic signed [CW-1:0] lo_s;
  logic signed [CW-1:0] hi_s;
  logic signed [CW-1:0] r_s;
  logic signed [CW-1:0] c_s;
  logic                 flag;

  assign hws   = win[3:1];
  assign span  = {hws, 1'b0};
  assign amin  = min_disp[5] ? 6'(-min_disp) : min_disp;
  assign amax  = max_disp[5] ? 6'(-max_disp) : max_disp;
  assign pad   = (amin > amax) ? amin : amax;
  assign hws_s = $signed({{(CW-3){1'b0}}, hws});
  assign pad_s = $signed({{(CW-6){1'b0}}, pad});
  assign r_s   = $signed({{(CW-8){1'b0}}, cr});
  assign c_s   = $signed({{(CW-8){1'b0}}, cc});
  assign lo_s  = pad_s + hws_s + CW'(1);
  assign hi_s  = $signed(CW'(IMAGE_SIZE)) - pad_s - hws_s - CW'(1);
  assign flag  = (r_s < lo_s) || (r_s >= hi_s) || (c_s < lo_s) || (c_s >= hi_s) ||
                 (cd < min_disp) || (cd > max_disp);

  // read address generation
  logic signed [5:0]    rsh;
  logic signed [5:0]    csh;
  logic                 use_sh;
  logic                 use_win;
  logic signed [CW-1:0] rr;
  logic signed [CW-1:0] rc;
  logic signed [CW-1:0] hc_s;
  logic signed [CW-1:0] wc_s;
  logic [2:0]           rv;
  logic [ADDR_W-1:0]    rd_addr;
  logic [ADDR_W-1:0]    ld_addr;
  logic                 ld_ok;
  logic                 st_we;
  logic [ADDR_W-1:0]    st_addr;
  logic [PIXEL_BITS-1:0] st_rdata;

  assign rsh     = row_off(v, cd);
  assign csh     = col_off(v, cd);
  assign use_sh  = (ph == RK_SHC) || (ph == RK_P);
  assign use_win = (ph == RK_Q) || (ph == RK_P);
  assign hc_s    = $signed({{(CW-4){1'b0}}, hc});
  assign wc_s    = $signed({{(CW-4){1'b0}}, wc});
  assign rv      = use_sh ? v : CENTRE_V;
  assign rr      = r_s + (use_sh ? {{(CW-6){rsh[5]}}, rsh} : CW'(0)) +
                   (use_win ? hc_s - hws_s : CW'(0));
  assign rc      = c_s + (use_sh ? {{(CW-6){csh[5]}}, csh} : CW'(0)) +
                   (use_win ? wc_s - hws_s : CW'(0));
  assign rd_addr = {rv, rr[AW-1:0], rc[AW-1:0]};
  assign ld_addr = {view, AW'(row), AW'(column)};
  assign ld_ok   = (view < 3'(VIEWS)) && (CW'(row) < CW'(IMAGE_SIZE)) &&
                   (CW'(column) < CW'(IMAGE_SIZE));
  assign in_stall = (state != S_IDLE);
  assign st_we   = in_valid && !in_stall && (command == CMD_LOAD) && ld_ok;
  assign st_addr = (state == S_IDLE) ? ld_addr : rd_addr;

  mcsc_store #(
    .IMAGE_SIZE (IMAGE_SIZE),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .addr  (st_addr),
    .wdata (pixel_value[PIXEL_BITS-1:0]),
    .rdata (st_rdata)
  );

  // per pixel compare
  logic [15:0] pix;
  logic [15:0] diff;
  logic [15:0] capped;
  logic        census_x;

  assign pix      = 16'(st_rdata);
  assign diff     = (pix > q_pix) ? pix - q_pix : q_pix - pix;
  assign capped   = (diff < trunc) ? diff : trunc;
  assign census_x = (pix >= sh_c) != (q_pix >= ref_c);

  // shared multiplier
  logic [AD_W-1:0]   ma;
  logic [16:0]       mb;
  logic [40:0]       prod;
  logic [NUM_W-1:0]  num_sum;

  always_comb begin
    unique case (state)
      S_DEN1: begin
        ma = AD_W'(win);
        mb = 17'(win);
      end
      S_DEN2, S_MUL3: begin
        ma = AD_W'(trunc);
        mb = tmp;
      end
      S_MUL1: begin
        ma = ad;
        mb = 17'(alpha);
      end
      S_MUL2: begin
        ma = AD_W'(cnt);
        mb = 17'(9'd256 - alpha);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod    = {17'b0, ma} * {24'b0, mb};
  assign num_sum = num + prod[NUM_W-1:0];

  // divider
  div_req_t          div_req;
  logic              div_done;
  logic [COST_W-1:0] div_quot;

  assign div_req.start    = (state == S_DIVGO);
  assign div_req.dividend = fin ? total : TOT_W'(num);
  assign div_req.divisor  = den;

  mcsc_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      tag_vld   <= 1'b0;
    end else begin
      tag_vld  <= (state == S_READ);
      tag_kind <= ph;

      if (tag_vld) begin
        unique case (tag_kind)
          RK_REFC: ref_c <= pix;
          RK_SHC:  sh_c  <= pix;
          RK_Q:    q_pix <= pix;
          RK_P: begin
            ad  <= ad + AD_W'(capped);
            cnt <= cnt + CNT_W'(census_x);
          end
        endcase
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid && command == CMD_COMPUTE) begin
            cr    <= row;
            cc    <= column;
            cd    <= disparity;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (flag) begin
            res_view <= CENTRE_V;
            res_cost <= '0;
            res_last <= 1'b1;
            res_oor  <= 1'b1;
            state    <= S_EMIT;
          end else if (cd == 6'sd0) begin
            res_view <= CENTRE_V;
            res_cost <= COST_ONE;
            res_last <= 1'b1;
            res_oor  <= 1'b0;
            state    <= S_EMIT;
          end else begin
            state <= S_DEN1;
          end
        end
        S_DEN1: begin
          tmp   <= prod[16:0];
          state <= S_DEN2;
        end
        S_DEN2: begin
          den   <= {prod[23:0], 8'b0};
          v     <= 3'd0;
          total <= '0;
          fin   <= 1'b0;
          ph    <= RK_REFC;
          hc    <= 4'd0;
          wc    <= 4'd0;
          ad    <= '0;
          cnt   <= '0;
          state <= S_READ;
        end
        S_READ: begin
          unique case (ph)
            RK_REFC: ph <= RK_SHC;
            RK_SHC: begin
              if (hws == 3'd0) state <= S_DRAIN;
              else ph <= RK_Q;
            end
            RK_Q: ph <= RK_P;
            RK_P: begin
              ph <= RK_Q;
              if (wc == span - 4'd1) begin
                wc <= 4'd0;
                if (hc == span - 4'd1) state <= S_DRAIN;
                else hc <= hc + 4'd1;
              end else begin
                wc <= wc + 4'd1;
              end
            end
          endcase
        end
        S_DRAIN: state <= S_MUL1;
        S_MUL1: begin
          num   <= prod[NUM_W-1:0];
          state <= S_MUL2;
        end
        S_MUL2: begin
          tmp   <= prod[16:0];
          state <= S_MUL3;
        end
        S_MUL3: begin
          num   <= num_sum;
          total <= total + TOT_W'(num_sum);
          if (v == CENTRE_V) begin
            v     <= v + 3'd1;
            ph    <= RK_REFC;
            hc    <= 4'd0;
            wc    <= 4'd0;
            ad    <= '0;
            cnt   <= '0;
            state <= S_READ;
          end else begin
            state <= S_DIVGO;
          end
        end
        S_DIVGO: state <= S_DIVWAIT;
        S_DIVWAIT: begin
          if (div_done) begin
            res_view <= fin ? CENTRE_V : v;
            res_cost <= div_quot;
            res_last <= fin;
            res_oor  <= 1'b0;
            state    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            result_view  <= res_view;
            cost         <= res_cost;
            last         <= res_last;
            out_of_range <= res_oor;
            if (res_last) begin
              state <= S_IDLE;
            end else if (v == LAST_V) begin
              fin   <= 1'b1;
              state <= S_DIVGO;
            end else begin
              v     <= v + 3'd1;
              ph    <= RK_REFC;
              hc    <= 4'd0;
              wc    <= 4'd0;
              ad    <= '0;
              cnt   <= '0;
              state <= S_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mcsc_checker.sv
// Port-level checks for the multiview census/SAD cost block, bound to its top.
// Depends on mcsc_pkg and multiview_census_sad_cost.
`default_nettype none

module mcsc_checker import mcsc_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  result_view,
  input wire logic [18:0] cost,
  input wire logic        last,
  input wire logic        out_of_range
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_last_centre: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> result_view == 3'(CENTRE))
    else $error("final result not on central view");

  a_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> last && cost == '0)
    else $error("flagged result not single zero cost");

  a_mid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !out_of_range && result_view != 3'(CENTRE))
    else $error("bad intermediate result");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind multiview_census_sad_cost mcsc_checker u_mcsc_checker (.*);

`default_nettype wire

>>> test/tb_multiview_census_sad_cost.sv
// Testbench for multiview_census_sad_cost: loads pixel windows, requests costs and
// checks every result against an in-bench cost predictor. Depends on mcsc_pkg and the RTL.
`timescale 1ns/1ps

module tb_multiview_census_sad_cost;
  timeunit 1ns;
  timeprecision 1ps;
  import mcsc_pkg::*;

  typedef enum logic {CMD_LOAD = 1'b0, CMD_COMPUTE = 1'b1} cmd_e;
  typedef enum logic [2:0] {
    REG_MIN_DISP = 3'd0, REG_MAX_DISP = 3'd1, REG_WINDOW = 3'd2,
    REG_BLEND = 3'd3, REG_TRUNC = 3'd4
  } reg_e;

  typedef struct {
    logic [2:0]  view;
    logic [18:0] cost;
    logic        last;
    logic        oor;
  } view_cost_t;

  localparam int ROW_COEF [0:6] = '{-1, -1, 0, 0, 0, 1, 1};
  localparam int COL_COEF [0:6] = '{-1, 1, -2, 0, 2, -1, 1};
  localparam int IMG = 256;
  localparam int PRESSURE_CYCLES = 3000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               command = 1'b0;
  logic [2:0]         view = '0;
  logic [7:0]         row = '0;
  logic [7:0]         column = '0;
  logic [15:0]        pixel_value = '0;
  logic signed [5:0]  disparity = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         result_view;
  logic [18:0]        cost;
  logic               last;
  logic               out_of_range;
  logic               cfg_write = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  multiview_census_sad_cost dut (
    .clk, .rst, .in_valid, .in_stall, .command, .view, .row, .column, .pixel_value,
    .disparity, .out_valid, .out_stall, .result_view, .cost, .last, .out_of_range,
    .cfg_write, .cfg_index, .cfg_data
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  bit [15:0]  pixel_mem [int];
  int         cfg_min = -8, cfg_max = 8, cfg_ws = 5, cfg_alpha = 128, cfg_trunc = 350;
  view_cost_t cost_q [$];

  int  requests_sent, results_checked, mismatches, config_phases, computes_sent;
  bit  quiet = 1'b0;
  bit  press_go = 1'b0, press_seen = 1'b0;
  int  hold_left, rcv_roll;

  function automatic int rd_px(int v, int r, int c);
    int key;
    key = v * 65536 + r * 256 + c;
    return pixel_mem.exists(key) ? int'(pixel_mem[key]) : 0;
  endfunction

  function automatic int shift_row(int v, int r, int d);
    return (1000 * r + 866 * ROW_COEF[v] * d + 500) / 1000;
  endfunction

  function automatic int shift_col(int v, int c, int d);
    return (2 * c + COL_COEF[v] * d + 1) / 2;
  endfunction

  function automatic bit is_flagged(int r, int c, int d);
    int hws, pad, lo, hi;
    hws = cfg_ws / 2;
    pad = cfg_min < 0 ? -cfg_min : cfg_min;
    if (cfg_max > pad) pad = cfg_max;
    if (-cfg_max > pad) pad = -cfg_max;
    lo = pad + hws + 1;
    hi = IMG - pad - hws - 1;
    return r < lo || r >= hi || c < lo || c >= hi || d < cfg_min || d > cfg_max;
  endfunction

  function automatic logic [18:0] q316(longint unsigned num, longint unsigned den);
    longint unsigned q;
    q = (num * 65536 + den / 2) / den;
    return q > 64'h7FFFF ? 19'h7FFFF : q[18:0];
  endfunction

  function automatic void predict_costs(int r, int c, int d);
    int hws, rs, cs, ref_c, sh_c, p, q, diff;
    longint unsigned ad, cnt, num, total, den;
    if (is_flagged(r, c, d)) begin
      cost_q.push_back('{CENTRE[2:0], 19'd0, 1'b1, 1'b1});
      return;
    end
    if (d == 0) begin
      cost_q.push_back('{CENTRE[2:0], COST_ONE, 1'b1, 1'b0});
      return;
    end
    hws = cfg_ws / 2;
    den = 256 * cfg_ws * cfg_ws * cfg_trunc;
    total = 0;
    for (int v = 0; v < VIEWS; v++) begin
      rs = shift_row(v, r, d);
      cs = shift_col(v, c, d);
      ref_c = rd_px(CENTRE, r, c);
      sh_c = rd_px(v, rs, cs);
      ad = 0;
      cnt = 0;
      for (int h = -hws; h < hws; h++) begin
        for (int w = -hws; w < hws; w++) begin
          p = rd_px(v, rs + h, cs + w);
          q = rd_px(CENTRE, r + h, c + w);
          diff = p > q ? p - q : q - p;
          ad += diff < cfg_trunc ? diff : cfg_trunc;
          if ((p >= sh_c) != (q >= ref_c)) cnt++;
        end
      end
      num = cfg_alpha * ad + (256 - cfg_alpha) * cnt * cfg_trunc;
      total += num;
      if (v != CENTRE) cost_q.push_back('{v[2:0], q316(num, den), 1'b0, 1'b0});
    end
    cost_q.push_back('{CENTRE[2:0], q316(total, den), 1'b1, 1'b0});
  endfunction

  function automatic void apply_reg(reg_e idx, logic [15:0] val);
    int s;
    case (idx)
      REG_MIN_DISP, REG_MAX_DISP: begin
        s = $signed(val[5:0]);
        s = s > 16 ? 16 : (s < -16 ? -16 : s);
        if (idx == REG_MIN_DISP) cfg_min = s;
        else cfg_max = s;
      end
      REG_WINDOW: cfg_ws = val[3:0] == 0 ? 1 : int'(val[3:0]);
      REG_BLEND:  cfg_alpha = val[8:0] > 256 ? 256 : int'(val[8:0]);
      REG_TRUNC:  cfg_trunc = val == 0 ? 1 : int'(val);
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int k;
    if (quiet) return 0;
    k = $urandom_range(99);
    if (k < 60) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_pixel();
    case ($urandom_range(3))
      0: return 16'($urandom_range(0, 400));
      1: return 16'($urandom);
      2: return 16'($urandom_range(30000, 30100));
      default: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  // called at a rising edge; returns at the edge that takes the request, or after a random idle gap
  task automatic send_request(cmd_e cmd, logic [2:0] v, int r, int c, logic [15:0] pv,
                              logic signed [5:0] d);
    bit taken;
    int gap;
    in_valid <= 1'b1;
    command <= cmd;
    view <= v;
    row <= r[7:0];
    column <= c[7:0];
    pixel_value <= pv;
    disparity <= d;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    if (cmd == CMD_LOAD) begin
      if (v < VIEWS) begin
        pixel_mem[v * 65536 + (r % 256) * 256 + (c % 256)] = pv;
        requests_sent++;
      end
    end else begin
      predict_costs(r % 256, c % 256, int'(d));
      requests_sent++;
      computes_sent++;
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_px(int v, int r, int c, bit refresh);
    if (refresh || !pixel_mem.exists(v * 65536 + r * 256 + c))
      send_request(CMD_LOAD, v[2:0], r, c, pick_pixel(), 6'sd0);
  endtask

  task automatic fill_window(int r, int c, int d, bit refresh);
    int hws, rs, cs;
    hws = cfg_ws / 2;
    for (int v = 0; v < VIEWS; v++) begin
      rs = shift_row(v, r, d);
      cs = shift_col(v, c, d);
      load_px(v, rs, cs, refresh);
      load_px(CENTRE, r, c, refresh);
      for (int h = -hws; h < hws; h++)
        for (int w = -hws; w < hws; w++) begin
          load_px(v, rs + h, cs + w, refresh);
          load_px(CENTRE, r + h, c + w, refresh);
        end
    end
  endtask

  task automatic compute(int r, int c, int d);
    if (!is_flagged(r, c, d) && d != 0) fill_window(r, c, d, 1'b0);
    send_request(CMD_COMPUTE, 3'($urandom), r, c, 16'($urandom), 6'(d));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (cost_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(reg_e idx, logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    apply_reg(idx, val);
  endtask

  task automatic set_config(logic [15:0] mn, logic [15:0] mx, logic [15:0] ws,
                            logic [15:0] a, logic [15:0] t);
    wait_idle();
    write_reg(REG_MIN_DISP, mn);
    write_reg(REG_MAX_DISP, mx);
    write_reg(REG_WINDOW, ws);
    write_reg(REG_BLEND, a);
    write_reg(REG_TRUNC, t);
    config_phases++;
  endtask

  task automatic test_defaults();
    compute(120, 130, 1);
    compute(120, 130, -1);
    compute(120, 130, 8);
    compute(120, 130, -8);
    compute(120, 130, 0);
    compute(120, 130, 9);
    compute(120, 130, -9);
    compute(10, 130, 2);
    compute(11, 11, 8);
    compute(244, 244, -8);
    compute(245, 130, 2);
    compute(130, 245, 2);
    compute(0, 255, 1);
    compute(255, 0, -3);
    send_request(CMD_LOAD, 3'd7, 255, 255, 16'hFFFF, 6'sd0);
  endtask

  task automatic test_register_extremes();
    set_config(16'h002C, 16'h0014, 16'h0001, 16'h0000, 16'h0000);
    compute(120, 130, 16);
    compute(120, 130, -16);
    compute(16, 130, 5);
    compute(17, 17, 5);
    set_config(16'h003F, 16'h0001, 16'h000F, 16'h0100, 16'hFFFF);
    compute(120, 130, 1);
    compute(120, 130, -1);
    set_config(16'h0005, 16'h003B, 16'h0003, 16'h012C, 16'h0001);
    compute(120, 130, 0);
    compute(120, 130, 3);
    compute(120, 130, -3);
    set_config(16'h0003, 16'h000C, 16'h0002, 16'h0001, 16'hFFFF);
    compute(120, 130, 3);
    compute(120, 130, 12);
    compute(120, 130, 7);
    set_config(16'hFFF0, 16'h0010, 16'h0010, 16'hFFFF, 16'h0000);
    compute(120, 130, 16);
    compute(120, 130, -5);
  endtask

  task automatic random_config();
    logic [15:0] mn, mx, ws, a, t;
    mn = 16'($signed(-$urandom_range(0, 6)));
    mx = 16'($urandom_range(0, 6));
    if ($urandom_range(4) == 0) mn = 16'($urandom);
    if ($urandom_range(4) == 0) mx = 16'($urandom);
    ws = $urandom_range(5) == 0 ? 16'($urandom_range(0, 9)) : 16'($urandom_range(2, 6));
    a = $urandom_range(5) == 0 ? 16'($urandom_range(257, 511)) : 16'($urandom_range(0, 256));
    case ($urandom_range(3))
      0: t = 16'($urandom_range(1, 20));
      1: t = 16'd350;
      2: t = 16'($urandom);
      default: t = 16'($urandom_range(200, 2000));
    endcase
    set_config(mn, mx, ws, a, t);
  endtask

  task automatic test_random(int target);
    int base, r0, c0, d, k;
    base = requests_sent;
    quiet = 1'b1;
    while (requests_sent - base < target) begin
      if (requests_sent - base > 60) quiet = 1'b0;
      if (($urandom_range(39) == 0) || (requests_sent == base)) random_config();
      r0 = $urandom_range(0, 1) ? 100 : 140;
      c0 = $urandom_range(0, 1) ? 110 : 150;
      k = $urandom_range(99);
      if (k < 25) begin
        repeat ($urandom_range(1, 5))
          send_request(CMD_LOAD, 3'($urandom), r0 + $urandom_range(0, 12) - 6,
                       c0 + $urandom_range(0, 12) - 6, pick_pixel(), 6'($urandom));
      end else if (k < 35) begin
        send_request(CMD_LOAD, 3'($urandom), $urandom_range(0, 255), $urandom_range(0, 255),
                     16'($urandom), 6'($urandom));
      end else begin
        d = $urandom_range(cfg_max - cfg_min + 4) + cfg_min - 2;
        if (k > 94) d = $signed(6'($urandom));
        if (d > 31) d = 31;
        if (d < -32) d = -32;
        if (k > 90 && k <= 94) compute($urandom_range(0, 255), $urandom_range(0, 255), d);
        else compute(r0, c0, d);
      end
    end
    quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    set_config(16'h003E, 16'h0002, 16'h0003, 16'h0080, 16'd350);
    for (int d = -2; d <= 2; d++) if (d != 0) fill_window(100, 110, d, 1'b0);
    quiet = 1'b1;
    press_go = !press_go;
    for (int n = 0; n < 6; n++) compute(100, 110, (n % 2) ? 2 : -1);
    quiet = 1'b0;
  endtask

  // receiver: random stalls unless quiet, plus one long hold when the backpressure test starts
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (press_go != press_seen) begin
      press_seen <= press_go;
      hold_left <= PRESSURE_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      rcv_roll = $urandom_range(99);
      if (rcv_roll < 70) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        hold_left <= rcv_roll < 96 ? $urandom_range(0, 2) : $urandom_range(15, 60);
      end
    end
  end

  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (cost_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: view %0d cost %0d last %0b oor %0b",
                   result_view, cost, last, out_of_range);
      end else begin
        if (result_view !== cost_q[0].view || cost !== cost_q[0].cost ||
            last !== cost_q[0].last || out_of_range !== cost_q[0].oor) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp view %0d cost %0d last %0b oor %0b, got %0d %0d %0b %0b",
                     cost_q[0].view, cost_q[0].cost, cost_q[0].last, cost_q[0].oor,
                     result_view, cost, last, out_of_range);
        end
        void'(cost_q.pop_front());
        results_checked++;
      end
    end
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_register_extremes();
    test_backpressure();
    test_random(330);
    wait_idle();
    repeat (100) @(posedge clk);
    $display("covered %0d requests (%0d cost requests), %0d results checked, %0d settings",
             requests_sent, computes_sent, results_checked, config_phases);
    if (mismatches == 0 && cost_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, cost_q.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/mcsc_pkg.sv
hw/rtl/mcsc_store.sv
hw/rtl/mcsc_divider.sv
hw/rtl/multiview_census_sad_cost.sv
hw/rtl/mcsc_checker.sv
test/tb_multiview_census_sad_cost.sv
